FILE: hw/rtl/rqsat_pkg.sv
// Shared constants for the rectangle/quad separating axis test pipeline.
// No dependencies; imported by rqsat_box, rqsat_axis and the top level.
package rqsat_pkg;

  localparam int unsigned QUAD_POINTS = 4;
  localparam int unsigned AXIS_COUNT  = 4;
  localparam int unsigned AXIS_STAGES = 5;
  localparam int unsigned PIPE_DEPTH  = AXIS_STAGES + 1;

endpackage

FILE: hw/rtl/rqsat_box.sv
// X and y axis interval test, delayed to line up with the slanted axis units.
// Depends on rqsat_pkg.
module rqsat_box #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rqsat_pkg::AXIS_STAGES-1:0]     en_i,
  input  logic signed [COORD_BITS-1:0]          px_i [rqsat_pkg::QUAD_POINTS],
  input  logic signed [COORD_BITS-1:0]          py_i [rqsat_pkg::QUAD_POINTS],
  input  logic signed [COORD_BITS-1:0]          rect_left_i,
  input  logic signed [COORD_BITS-1:0]          rect_top_i,
  input  logic signed [COORD_BITS-1:0]          rect_right_i,
  input  logic signed [COORD_BITS-1:0]          rect_bottom_i,
  output logic                                  sep_o
);
  import rqsat_pkg::*;

  logic signed [COORD_BITS-1:0] minx_d, maxx_d, miny_d, maxy_d;
  logic signed [COORD_BITS-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic                         sep_d;
  logic [AXIS_STAGES-2:0]       sep_q;

  always_comb begin
    minx_d = px_i[0];
    maxx_d = px_i[0];
    miny_d = py_i[0];
    maxy_d = py_i[0];
    for (int i = 1; i < QUAD_POINTS; i++) begin
      if (px_i[i] < minx_d) minx_d = px_i[i];
      if (px_i[i] > maxx_d) maxx_d = px_i[i];
      if (py_i[i] < miny_d) miny_d = py_i[i];
      if (py_i[i] > maxy_d) maxy_d = py_i[i];
    end
  end

  assign sep_d = (rect_left_i >= maxx_q) || (minx_q >= rect_right_i) ||
                 (rect_top_i >= maxy_q) || (miny_q >= rect_bottom_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      minx_q <= minx_d;
      maxx_q <= maxx_d;
      miny_q <= miny_d;
      maxy_q <= maxy_d;
    end
    if (en_i[1]) begin
      sep_q[0] <= sep_d;
    end
    for (int k = 1; k < AXIS_STAGES - 1; k++) begin
      if (en_i[k+1]) begin
        sep_q[k] <= sep_q[k-1];
      end
    end
  end

  assign sep_o = sep_q[AXIS_STAGES-2];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i[0] |=> (minx_q <= maxx_q) && (miny_q <= maxy_q))
    else $error("quad extent inverted");

endmodule

FILE: hw/rtl/rqsat_axis.sv
// One slanted axis: perpendicular of an edge, projections, extents, overlap compare.
// Depends on rqsat_pkg.
module rqsat_axis #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rqsat_pkg::AXIS_STAGES-1:0]     en_i,
  input  logic signed [COORD_BITS-1:0]          pa_x_i,
  input  logic signed [COORD_BITS-1:0]          pa_y_i,
  input  logic signed [COORD_BITS-1:0]          pb_x_i,
  input  logic signed [COORD_BITS-1:0]          pb_y_i,
  input  logic signed [COORD_BITS-1:0]          px_i [rqsat_pkg::QUAD_POINTS],
  input  logic signed [COORD_BITS-1:0]          py_i [rqsat_pkg::QUAD_POINTS],
  input  logic signed [COORD_BITS-1:0]          rect_left_i,
  input  logic signed [COORD_BITS-1:0]          rect_top_i,
  input  logic signed [COORD_BITS-1:0]          rect_right_i,
  input  logic signed [COORD_BITS-1:0]          rect_bottom_i,
  output logic                                  sep_o
);
  import rqsat_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 1;
  localparam int unsigned SW = 2 * COORD_BITS + 2;

  logic signed [DW-1:0] ax_q, ay_q;
  logic signed [PW-1:0] lx_q, rx_q, ty_q, by_q;
  logic signed [PW-1:0] qx_q [QUAD_POINTS];
  logic signed [PW-1:0] qy_q [QUAD_POINTS];
  logic signed [SW-1:0] rlo_d, rhi_d, rlo_q, rhi_q, rlo4_q, rhi4_q;
  logic signed [SW-1:0] q_q [QUAD_POINTS];
  logic signed [SW-1:0] qlo_d, qhi_d, qlo_q, qhi_q;
  logic                 sep_q;

  always_comb begin
    rlo_d = SW'((lx_q < rx_q) ? lx_q : rx_q) + SW'((ty_q < by_q) ? ty_q : by_q);
    rhi_d = SW'((lx_q > rx_q) ? lx_q : rx_q) + SW'((ty_q > by_q) ? ty_q : by_q);
  end

  always_comb begin
    qlo_d = q_q[0];
    qhi_d = q_q[0];
    for (int i = 1; i < QUAD_POINTS; i++) begin
      if (q_q[i] < qlo_d) qlo_d = q_q[i];
      if (q_q[i] > qhi_d) qhi_d = q_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ax_q <= DW'(pa_y_i) - DW'(pb_y_i);
      ay_q <= DW'(pb_x_i) - DW'(pa_x_i);
    end
    if (en_i[1]) begin
      lx_q <= PW'(rect_left_i) * PW'(ax_q);
      rx_q <= PW'(rect_right_i) * PW'(ax_q);
      ty_q <= PW'(rect_top_i) * PW'(ay_q);
      by_q <= PW'(rect_bottom_i) * PW'(ay_q);
      for (int i = 0; i < QUAD_POINTS; i++) begin
        qx_q[i] <= PW'(px_i[i]) * PW'(ax_q);
        qy_q[i] <= PW'(py_i[i]) * PW'(ay_q);
      end
    end
    if (en_i[2]) begin
      rlo_q <= rlo_d;
      rhi_q <= rhi_d;
      for (int i = 0; i < QUAD_POINTS; i++) begin
        q_q[i] <= SW'(qx_q[i]) + SW'(qy_q[i]);
      end
    end
    if (en_i[3]) begin
      qlo_q  <= qlo_d;
      qhi_q  <= qhi_d;
      rlo4_q <= rlo_q;
      rhi4_q <= rhi_q;
    end
    if (en_i[4]) begin
      sep_q <= (rlo4_q >= qhi_q) || (qlo_q >= rhi4_q);
    end
  end

  assign sep_o = sep_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i[2] |=> (rlo_q <= rhi_q))
    else $error("rectangle extent inverted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i[3] |=> (qlo_q <= qhi_q))
    else $error("quad extent inverted");

endmodule

FILE: hw/rtl/rect_quad_separating_axis_test_top.sv
// Rectangle versus quadrilateral overlap test by separating axes, top level.
// Depends on rqsat_pkg, rqsat_box and rqsat_axis.
//
// Usage: drive the rectangle (left, top, right, bottom) and the four quad
// points, all signed Q12.4 of COORD_BITS, and raise start_i. A beat is taken
// at each rising edge with start_i high and busy_o low; busy_o stays low, so
// one beat can be taken every cycle.
// Each beat gives one result: done_o is high for one cycle with overlaps_o,
// and results leave in the order the beats came in.
// The pipeline has six stages: input register, edge perpendicular,
// projection multipliers, projection sums, min/max, separation compare.
// overlaps_o is 1 when none of x, y and the perpendiculars of P0->P1, P0->P2,
// P3->P1 and P3->P2 separates the shapes; touching counts as separated.
// Reset clears the valid pipeline; beats in flight are dropped and no result
// appears for them. The receiver cannot stall: each result is taken in the
// cycle it is shown.
module rect_quad_separating_axis_test_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] rect_left_i,
  input  logic signed [COORD_BITS-1:0] rect_top_i,
  input  logic signed [COORD_BITS-1:0] rect_right_i,
  input  logic signed [COORD_BITS-1:0] rect_bottom_i,
  input  logic signed [COORD_BITS-1:0] p0_x_i,
  input  logic signed [COORD_BITS-1:0] p0_y_i,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  output logic                         done_o,
  output logic                         overlaps_o
);
  import rqsat_pkg::*;

  localparam int unsigned AxisFrom [AXIS_COUNT] = '{0, 0, 3, 3};
  localparam int unsigned AxisTo   [AXIS_COUNT] = '{1, 2, 1, 2};

  logic                         accept;
  logic [PIPE_DEPTH-1:0]        vld_q;
  logic signed [COORD_BITS-1:0] l0_q, t0_q, r0_q, b0_q;
  logic signed [COORD_BITS-1:0] l1_q, t1_q, r1_q, b1_q;
  logic signed [COORD_BITS-1:0] px0_q [QUAD_POINTS];
  logic signed [COORD_BITS-1:0] py0_q [QUAD_POINTS];
  logic signed [COORD_BITS-1:0] px1_q [QUAD_POINTS];
  logic signed [COORD_BITS-1:0] py1_q [QUAD_POINTS];
  logic [AXIS_COUNT-1:0]        sep_axis;
  logic                         sep_xy;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      l0_q     <= rect_left_i;
      t0_q     <= rect_top_i;
      r0_q     <= rect_right_i;
      b0_q     <= rect_bottom_i;
      px0_q[0] <= p0_x_i;
      py0_q[0] <= p0_y_i;
      px0_q[1] <= p1_x_i;
      py0_q[1] <= p1_y_i;
      px0_q[2] <= p2_x_i;
      py0_q[2] <= p2_y_i;
      px0_q[3] <= p3_x_i;
      py0_q[3] <= p3_y_i;
    end
    if (vld_q[0]) begin
      l1_q  <= l0_q;
      t1_q  <= t0_q;
      r1_q  <= r0_q;
      b1_q  <= b0_q;
      px1_q <= px0_q;
      py1_q <= py0_q;
    end
  end

  rqsat_box #(
    .COORD_BITS(COORD_BITS)
  ) u_box (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (vld_q[AXIS_STAGES-1:0]),
    .px_i          (px0_q),
    .py_i          (py0_q),
    .rect_left_i   (l1_q),
    .rect_top_i    (t1_q),
    .rect_right_i  (r1_q),
    .rect_bottom_i (b1_q),
    .sep_o         (sep_xy)
  );

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    rqsat_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (vld_q[AXIS_STAGES-1:0]),
      .pa_x_i        (px0_q[AxisFrom[g]]),
      .pa_y_i        (py0_q[AxisFrom[g]]),
      .pb_x_i        (px0_q[AxisTo[g]]),
      .pb_y_i        (py0_q[AxisTo[g]]),
      .px_i          (px1_q),
      .py_i          (py1_q),
      .rect_left_i   (l1_q),
      .rect_top_i    (t1_q),
      .rect_right_i  (r1_q),
      .rect_bottom_i (b1_q),
      .sep_o         (sep_axis[g])
    );
  end

  assign done_o     = vld_q[PIPE_DEPTH-1];
  assign overlaps_o = !(sep_xy || (|sep_axis));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_DEPTH))
    else $error("result beat without a matching start");

endmodule
